/* sv/three_channel_stopwatch_top_assert.svh */
// Assertion macros for the stopwatch block.
// Both take a label, a clock, a reset, an antecedent and a consequent.
`ifndef THREE_CHANNEL_STOPWATCH_TOP_ASSERT_SVH
`define THREE_CHANNEL_STOPWATCH_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// consequent holds in the same cycle as the antecedent
`define TCS_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: assertion failed");

// consequent holds in the cycle after the antecedent
`define TCS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: assertion failed");

`else

`define TCS_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define TCS_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

/* sv/tcs_pkg.sv */
`default_nettype none

package tcs_pkg;

   // timer counts in milliseconds
   localparam int unsigned MS_W = 23;
   localparam logic [MS_W-1:0] MS_MAX = 23'd8388607;
   // 99:59.99 in milliseconds
   localparam logic [MS_W-1:0] SHOW_MAX = 23'd5999999;

   // long press register
   localparam int unsigned LPT_W = 16;
   localparam logic [LPT_W-1:0] LPT_RESET = 16'd1000;

   localparam int unsigned TIMER_COUNT_DEF = 3;

   // display fields
   localparam int unsigned MIN_W = 7;
   localparam int unsigned SEC_W = 6;
   localparam int unsigned CENTI_W = 7;

   // quotients of the clipped total: by 10, by 1000, by 60000
   localparam int unsigned Q10_W = 20;
   localparam int unsigned Q1000_W = 13;
   localparam int unsigned Q60000_W = 7;

   // reciprocal multipliers, exact for any total below 2^MS_W
   localparam int unsigned RECIP_W = 24;
   localparam int unsigned PROD_W = MS_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP_10 = 24'd13421773;
   localparam int unsigned SHIFT_10 = 27;
   localparam logic [RECIP_W-1:0] RECIP_1000 = 24'd8589935;
   localparam int unsigned SHIFT_1000 = 33;
   localparam logic [RECIP_W-1:0] RECIP_60000 = 24'd9162597;
   localparam int unsigned SHIFT_60000 = 39;

   localparam int unsigned CENTI_PER_SEC = 100;
   localparam int unsigned SEC_PER_MIN = 60;

endpackage

`default_nettype wire

/* sv/tcs_conv.sv */
`default_nettype none

// Turns a clipped millisecond total into minutes, seconds and hundredths
// over two register stages, and flags a change of the shown value.
module tcs_conv #(
   parameter int unsigned TAG_W = 5
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        in_valid,
   output logic                             in_ready,
   input  wire logic [tcs_pkg::MS_W-1:0]    in_total,
   input  wire logic [TAG_W-1:0]            in_tag,
   output logic                             out_valid,
   input  wire logic                        out_ready,
   output logic [tcs_pkg::MIN_W-1:0]        out_minutes,
   output logic [tcs_pkg::SEC_W-1:0]        out_seconds,
   output logic [tcs_pkg::CENTI_W-1:0]      out_centiseconds,
   output logic [TAG_W-1:0]                 out_tag,
   output logic                             out_changed
);
   import tcs_pkg::*;

   `include "three_channel_stopwatch_top_assert.svh"

   logic                  s2_valid_ff;
   logic                  s2_ready;
   logic                  s2_load;
   logic                  s3_valid_ff;
   logic                  s3_ready;
   logic                  s3_load;
   logic [PROD_W-1:0]     p10;
   logic [PROD_W-1:0]     p1000;
   logic [PROD_W-1:0]     p60000;
   logic [Q10_W-1:0]      q10_ff;
   logic [Q1000_W-1:0]    q1000_ff;
   logic [Q60000_W-1:0]   q60000_ff;
   logic [TAG_W-1:0]      tag2_ff;
   logic [Q10_W-1:0]      cs_wide;
   logic [Q1000_W-1:0]    sec_wide;
   logic                  changed_in;
   logic [Q10_W-1:0]      last_q10_ff;
   logic                  shown_valid_ff;
   logic [MIN_W-1:0]      minutes_ff;
   logic [SEC_W-1:0]      seconds_ff;
   logic [CENTI_W-1:0]    centi_ff;
   logic [TAG_W-1:0]      tag3_ff;
   logic                  changed_ff;

   // stage handshake: a stage takes a beat when it is empty or drains
   assign s3_ready = !s3_valid_ff || out_ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign in_ready = s2_ready;
   assign s2_load  = in_valid && s2_ready;
   assign s3_load  = s2_valid_ff && s3_ready;

   // reciprocal multiplies, one per quotient
   assign p10    = PROD_W'(in_total) * PROD_W'(RECIP_10);
   assign p1000  = PROD_W'(in_total) * PROD_W'(RECIP_1000);
   assign p60000 = PROD_W'(in_total) * PROD_W'(RECIP_60000);

   // split the quotients into digits of the display
   assign cs_wide  = q10_ff - (Q10_W'(q1000_ff) * Q10_W'(CENTI_PER_SEC));
   assign sec_wide = q1000_ff - (Q1000_W'(q60000_ff) * Q1000_W'(SEC_PER_MIN));
   assign changed_in = !shown_valid_ff || (q10_ff != last_q10_ff);

   // valid bits and last shown value
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff    <= 1'b0;
         s3_valid_ff    <= 1'b0;
         shown_valid_ff <= 1'b0;
         last_q10_ff    <= '0;
      end else begin
         if (s2_ready) begin
            s2_valid_ff <= in_valid;
         end
         if (s3_ready) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (s3_load) begin
            shown_valid_ff <= 1'b1;
            last_q10_ff    <= q10_ff;
         end
      end
   end

   // payload: hold while the next stage is stalled
   always_ff @(posedge clock) begin
      if (s2_load) begin
         q10_ff    <= p10[SHIFT_10 +: Q10_W];
         q1000_ff  <= p1000[SHIFT_1000 +: Q1000_W];
         q60000_ff <= p60000[SHIFT_60000 +: Q60000_W];
         tag2_ff   <= in_tag;
      end
      if (s3_load) begin
         minutes_ff <= q60000_ff;
         seconds_ff <= sec_wide[SEC_W-1:0];
         centi_ff   <= cs_wide[CENTI_W-1:0];
         tag3_ff    <= tag2_ff;
         changed_ff <= changed_in;
      end
   end

   assign out_valid        = s3_valid_ff;
   assign out_minutes      = minutes_ff;
   assign out_seconds      = seconds_ff;
   assign out_centiseconds = centi_ff;
   assign out_tag          = tag3_ff;
   assign out_changed      = changed_ff;

   `TCS_ASSERT_IMPL(a_seconds_range, clock, reset, s3_valid_ff, seconds_ff < 6'd60)
   `TCS_ASSERT_IMPL(a_centi_range, clock, reset, s3_valid_ff, centi_ff < 7'd100)
   `TCS_ASSERT_IMPL(a_minutes_range, clock, reset, s3_valid_ff, minutes_ff < 7'd100)
   `TCS_ASSERT_NEXT(a_first_changed, clock, reset, s3_load && !shown_valid_ff, changed_ff)

endmodule

`default_nettype wire

/* sv/three_channel_stopwatch_top.sv */
`default_nettype none

// Channel  Direction  Handshake                 Payload
// req      in         req_valid / req_ready     start, stop and mode levels
// rsp      out        rsp_valid / rsp_ready     shown time, LEDs, selection, change flag
// csr      in         csr_wr_en                 long press length in ticks
//
// One beat is taken per cycle while rsp is not stalled: the beat lands in the
// state register stage, then moves through the reciprocal multiplier stage
// and the digit split stage.
// Reset clears every timer, selects timer zero with its LED lit and loads a
// long press of 1000 ticks; the first result always flags a change.
// A stalled rsp holds each stage; a stage takes a new beat once the next drains.
module three_channel_stopwatch_top #(
   parameter int unsigned TIMER_COUNT = tcs_pkg::TIMER_COUNT_DEF,
   localparam int unsigned SEL_W = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic                          req_start_level,
   input  wire logic                          req_stop_level,
   input  wire logic                          req_mode_level,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [tcs_pkg::MIN_W-1:0]          rsp_minutes,
   output logic [tcs_pkg::SEC_W-1:0]          rsp_seconds,
   output logic [tcs_pkg::CENTI_W-1:0]        rsp_centiseconds,
   output logic [TIMER_COUNT-1:0]             rsp_led_mask,
   output logic [SEL_W-1:0]                   rsp_selected,
   output logic                               rsp_display_changed,
   input  wire logic                          csr_wr_en,
   input  wire logic [tcs_pkg::LPT_W-1:0]     csr_wr_data
);
   import tcs_pkg::*;

   `include "three_channel_stopwatch_top_assert.svh"

   localparam int unsigned TAG_W = TIMER_COUNT + SEL_W;

   logic                    accept;
   logic [LPT_W-1:0]        lpt_ff;
   logic [SEL_W-1:0]        sel_ff;
   logic [SEL_W-1:0]        sel_in;
   logic                    mode_prev_ff;
   logic                    stop_prev_ff;
   logic                    hold_active_ff;
   logic                    hold_active_in;
   logic [LPT_W-1:0]        hold_count_ff;
   logic [LPT_W-1:0]        hold_count_in;
   logic [TIMER_COUNT-1:0]  running_ff;
   logic [TIMER_COUNT-1:0]  running_in;
   logic [MS_W-1:0]         run_ff [TIMER_COUNT];
   logic [MS_W-1:0]         run_in [TIMER_COUNT];
   logic [MS_W-1:0]         committed_ff [TIMER_COUNT];
   logic [MS_W-1:0]         committed_in [TIMER_COUNT];
   logic [TIMER_COUNT-1:0]  leds_ff;
   logic [TIMER_COUNT-1:0]  leds_in;
   logic                    fire;
   logic                    stop_hit;
   logic                    live_sel;
   logic [MS_W:0]           sum;
   logic [MS_W-1:0]         sum_sat;
   logic [MS_W:0]           total_raw;
   logic [MS_W-1:0]         total_in;
   logic                    s1_valid_ff;
   logic                    s1_ready;
   logic [MS_W-1:0]         total_ff;
   logic [TAG_W-1:0]        tag1_ff;
   logic                    conv_ready;
   logic [TAG_W-1:0]        out_tag;

   assign s1_ready  = !s1_valid_ff || conv_ready;
   assign req_ready = s1_ready;
   assign accept    = req_valid && s1_ready;

   // next state for one tick, in the order: run, mode, hold, stop, display
   always_comb begin
      running_in     = running_ff;
      leds_in        = leds_ff;
      sel_in         = sel_ff;
      hold_active_in = hold_active_ff;
      hold_count_in  = hold_count_ff;
      for (int i = 0; i < TIMER_COUNT; i++) begin
         committed_in[i] = committed_ff[i];
         run_in[i]       = run_ff[i];
         if (running_ff[i] && (run_ff[i] != MS_MAX)) begin
            run_in[i] = run_ff[i] + 1'b1;
         end
      end

      // advance the selection on a mode edge
      if (req_mode_level && !mode_prev_ff) begin
         sel_in  = (sel_ff == SEL_W'(TIMER_COUNT - 1)) ? '0 : sel_ff + 1'b1;
         leds_in = TIMER_COUNT'(1) << sel_in;
      end

      // track the start hold
      if (req_start_level && !hold_active_ff) begin
         hold_active_in = 1'b1;
         hold_count_in  = '0;
      end else if (req_start_level) begin
         if (hold_count_ff != '1) begin
            hold_count_in = hold_count_ff + 1'b1;
         end
      end else begin
         hold_active_in = 1'b0;
         hold_count_in  = '0;
      end
      fire = hold_active_in && (hold_count_in >= lpt_ff);
      if (fire) begin
         for (int i = 0; i < TIMER_COUNT; i++) begin
            running_in[i] = 1'b1;
            run_in[i]     = '0;
         end
         leds_in        = '1;
         hold_active_in = 1'b0;
         hold_count_in  = '0;
      end

      // commit and halt the selected timer on a stop edge
      live_sel = running_in[sel_in];
      sum      = {1'b0, committed_ff[sel_in]} + {1'b0, run_in[sel_in]};
      sum_sat  = (sum > {1'b0, MS_MAX}) ? MS_MAX : sum[MS_W-1:0];
      stop_hit = req_stop_level && !stop_prev_ff && live_sel;
      if (stop_hit) begin
         committed_in[sel_in] = sum_sat;
         run_in[sel_in]       = '0;
         running_in[sel_in]   = 1'b0;
      end

      // shown total, clipped to the display range
      total_raw = live_sel ? sum : {1'b0, committed_ff[sel_in]};
      total_in  = (total_raw > {1'b0, SHOW_MAX}) ? SHOW_MAX : total_raw[MS_W-1:0];
   end

   // control and timer state
   always_ff @(posedge clock) begin
      if (reset) begin
         lpt_ff         <= LPT_RESET;
         sel_ff         <= '0;
         mode_prev_ff   <= 1'b0;
         stop_prev_ff   <= 1'b0;
         hold_active_ff <= 1'b0;
         hold_count_ff  <= '0;
         running_ff     <= '0;
         leds_ff        <= TIMER_COUNT'(1);
         s1_valid_ff    <= 1'b0;
         for (int i = 0; i < TIMER_COUNT; i++) begin
            run_ff[i]       <= '0;
            committed_ff[i] <= '0;
         end
      end else begin
         if (csr_wr_en) begin
            lpt_ff <= csr_wr_data;
         end
         if (s1_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (accept) begin
            sel_ff         <= sel_in;
            mode_prev_ff   <= req_mode_level;
            stop_prev_ff   <= req_stop_level;
            hold_active_ff <= hold_active_in;
            hold_count_ff  <= hold_count_in;
            running_ff     <= running_in;
            leds_ff        <= leds_in;
            for (int i = 0; i < TIMER_COUNT; i++) begin
               run_ff[i]       <= run_in[i];
               committed_ff[i] <= committed_in[i];
            end
         end
      end
   end

   // beat payload into the first stage
   always_ff @(posedge clock) begin
      if (accept) begin
         total_ff <= total_in;
         tag1_ff  <= {leds_in, sel_in};
      end
   end

   tcs_conv #(
      .TAG_W (TAG_W)
   ) u_conv (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (s1_valid_ff),
      .in_ready         (conv_ready),
      .in_total         (total_ff),
      .in_tag           (tag1_ff),
      .out_valid        (rsp_valid),
      .out_ready        (rsp_ready),
      .out_minutes      (rsp_minutes),
      .out_seconds      (rsp_seconds),
      .out_centiseconds (rsp_centiseconds),
      .out_tag          (out_tag),
      .out_changed      (rsp_display_changed)
   );

   assign rsp_led_mask = out_tag[TAG_W-1:SEL_W];
   assign rsp_selected = out_tag[SEL_W-1:0];

   `TCS_ASSERT_IMPL(a_sel_range, clock, reset, 1'b1, sel_ff <= SEL_W'(TIMER_COUNT - 1))
   `TCS_ASSERT_NEXT(a_fire_lights_all, clock, reset, accept && fire, (&leds_ff) && !hold_active_ff)
   `TCS_ASSERT_IMPL(a_count_needs_hold, clock, reset, hold_count_ff != '0, hold_active_ff)
   `TCS_ASSERT_IMPL(a_total_clipped, clock, reset, s1_valid_ff, total_ff <= SHOW_MAX)

endmodule

`default_nettype wire

/* tb/stopwatch_checker.sv */
module stopwatch_checker (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   input  wire logic                        req_ready,
   input  wire logic                        req_start_level,
   input  wire logic                        req_stop_level,
   input  wire logic                        req_mode_level,
   input  wire logic                        rsp_valid,
   input  wire logic                        rsp_ready,
   input  wire logic [tcs_pkg::MIN_W-1:0]   rsp_minutes,
   input  wire logic [tcs_pkg::SEC_W-1:0]   rsp_seconds,
   input  wire logic [tcs_pkg::CENTI_W-1:0] rsp_centiseconds,
   input  wire logic [2:0]                  rsp_led_mask,
   input  wire logic [1:0]                  rsp_selected,
   input  wire logic                        rsp_display_changed,
   input  wire logic                        csr_wr_en,
   input  wire logic [tcs_pkg::LPT_W-1:0]   csr_wr_data,
   output int                               errors,
   output int                               awaiting,
   output int                               readouts_checked,
   output int                               group_starts,
   output int                               commits
);
   import tcs_pkg::*;

   localparam int unsigned NT = TIMER_COUNT_DEF;

   typedef struct packed {
      logic [MIN_W-1:0]   minutes;
      logic [SEC_W-1:0]   seconds;
      logic [CENTI_W-1:0] centiseconds;
      logic [NT-1:0]      led_mask;
      logic [1:0]         selected;
      logic               changed;
   } readout_type;

   readout_type expected_readouts[$];
   readout_type want;
   readout_type fresh;

   // stopwatch state as the block should hold it
   logic [LPT_W-1:0] press_ticks;
   logic [1:0]       sel_timer;
   logic             mode_was;
   logic             stop_was;
   logic             holding;
   logic [LPT_W-1:0] held_ticks;
   logic [NT-1:0]    running;
   logic [MS_W-1:0]  banked_ms [NT];
   logic [MS_W-1:0]  lap_ms [NT];
   logic [NT-1:0]    lit;
   logic [MS_W-1:0]  prev_shown;
   logic             shown_ok;

   task automatic clear_model();
      press_ticks = LPT_RESET;
      sel_timer   = '0;
      mode_was    = 1'b0;
      stop_was    = 1'b0;
      holding     = 1'b0;
      held_ticks  = '0;
      running     = '0;
      for (int i = 0; i < NT; i++) begin
         banked_ms[i] = '0;
         lap_ms[i]    = '0;
      end
      lit        = NT'(1);
      prev_shown = '0;
      shown_ok   = 1'b0;
   endtask

   // advance one millisecond and work out the readout it yields
   task automatic tick_stopwatch(input logic st, input logic sp, input logic md,
                                 output readout_type r);
      int unsigned total;
      int unsigned mins;
      int unsigned secs;
      int unsigned centi;
      int unsigned shown;
      logic [MS_W:0] sum;
      // running timers count up, saturating
      for (int i = 0; i < NT; i++)
         if (running[i] && lap_ms[i] != MS_MAX)
            lap_ms[i] = lap_ms[i] + 1'b1;
      // mode edge steps the selection
      if (md && !mode_was) begin
         sel_timer = (sel_timer == 2'(NT - 1)) ? 2'd0 : sel_timer + 2'd1;
         lit = '0;
         lit[sel_timer] = 1'b1;
      end
      mode_was = md;
      // start hold: count ticks held, fire once the length is reached
      if (st && !holding) begin
         holding    = 1'b1;
         held_ticks = '0;
      end else if (st) begin
         if (held_ticks != '1)
            held_ticks = held_ticks + 1'b1;
      end else begin
         holding    = 1'b0;
         held_ticks = '0;
      end
      if (holding && held_ticks >= press_ticks) begin
         running = '1;
         for (int i = 0; i < NT; i++)
            lap_ms[i] = '0;
         lit        = '1;
         holding    = 1'b0;
         held_ticks = '0;
         group_starts++;
      end
      // stop edge banks the selected timer's lap and halts it
      if (sp && !stop_was && running[sel_timer]) begin
         sum = {1'b0, banked_ms[sel_timer]} + {1'b0, lap_ms[sel_timer]};
         banked_ms[sel_timer] = (sum > {1'b0, MS_MAX}) ? MS_MAX : sum[MS_W-1:0];
         lap_ms[sel_timer]    = '0;
         running[sel_timer]   = 1'b0;
         commits++;
      end
      stop_was = sp;
      // split the clipped total into display digits
      total = 32'(banked_ms[sel_timer]);
      if (running[sel_timer])
         total = total + 32'(lap_ms[sel_timer]);
      if (total > 32'(SHOW_MAX))
         total = 32'(SHOW_MAX);
      mins  = total / 60000;
      secs  = (total / 1000) % 60;
      centi = (total % 1000) / 10;
      shown = mins * 60000 + secs * 1000 + centi * 10;
      r.minutes      = mins[MIN_W-1:0];
      r.seconds      = secs[SEC_W-1:0];
      r.centiseconds = centi[CENTI_W-1:0];
      r.led_mask     = lit;
      r.selected     = sel_timer;
      r.changed      = !shown_ok || (shown[MS_W-1:0] != prev_shown);
      prev_shown     = shown[MS_W-1:0];
      shown_ok       = 1'b1;
   endtask

   task automatic compare_field(input string what, input logic [31:0] exp_val,
                                input logic [31:0] got_val);
      if (got_val !== exp_val) begin
         errors++;
         $display("%0t: %s expected %0d, got %0d", $time, what, exp_val, got_val);
      end
   endtask

   // watch all three ports at each rising edge
   always @(posedge clock) begin
      if (reset) begin
         clear_model();
         expected_readouts.delete();
      end else begin
         if (csr_wr_en)
            press_ticks = csr_wr_data;
         // retire the oldest readout before queueing a new one
         if (rsp_valid && rsp_ready) begin
            if (expected_readouts.size() == 0) begin
               errors++;
               $display("%0t: readout beat with nothing expected", $time);
            end else begin
               want = expected_readouts.pop_front();
               compare_field("minutes", 32'(want.minutes), 32'(rsp_minutes));
               compare_field("seconds", 32'(want.seconds), 32'(rsp_seconds));
               compare_field("centiseconds", 32'(want.centiseconds),
                             32'(rsp_centiseconds));
               compare_field("led_mask", 32'(want.led_mask), 32'(rsp_led_mask));
               compare_field("selected", 32'(want.selected), 32'(rsp_selected));
               compare_field("display_changed", 32'(want.changed),
                             32'(rsp_display_changed));
               readouts_checked++;
            end
         end
         if (req_valid && req_ready) begin
            tick_stopwatch(req_start_level, req_stop_level, req_mode_level, fresh);
            expected_readouts.push_back(fresh);
         end
      end
      awaiting = expected_readouts.size();
   end

endmodule

/* tb/tb_top.sv */
module tb_top;
   import tcs_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int LONG_STALL     = 300;
   localparam int PHASE_TICKS    = 140;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_start_level = 1'b0;
   logic               req_stop_level = 1'b0;
   logic               req_mode_level = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [MIN_W-1:0]   rsp_minutes;
   logic [SEC_W-1:0]   rsp_seconds;
   logic [CENTI_W-1:0] rsp_centiseconds;
   logic [2:0]         rsp_led_mask;
   logic [1:0]         rsp_selected;
   logic               rsp_display_changed;
   logic               csr_wr_en = 1'b0;
   logic [LPT_W-1:0]   csr_wr_data = '0;

   int errors;
   int awaiting;
   int readouts_checked;
   int group_starts;
   int commits;

   bit idling = 1'b1;
   int long_stall_asks = 0;
   int long_stall_done = 0;
   int long_stall_left = 0;
   int ready_gap = 0;
   int quiet_cycles = 0;
   int ticks_sent = 0;
   int unsigned press_plan [7] = '{3, 1, 6, 65535, 2, 10, 4};

   always #5 clock = ~clock;

   three_channel_stopwatch_top dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_start_level     (req_start_level),
      .req_stop_level      (req_stop_level),
      .req_mode_level      (req_mode_level),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_minutes         (rsp_minutes),
      .rsp_seconds         (rsp_seconds),
      .rsp_centiseconds    (rsp_centiseconds),
      .rsp_led_mask        (rsp_led_mask),
      .rsp_selected        (rsp_selected),
      .rsp_display_changed (rsp_display_changed),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data)
   );

   stopwatch_checker watch (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_start_level     (req_start_level),
      .req_stop_level      (req_stop_level),
      .req_mode_level      (req_mode_level),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_minutes         (rsp_minutes),
      .rsp_seconds         (rsp_seconds),
      .rsp_centiseconds    (rsp_centiseconds),
      .rsp_led_mask        (rsp_led_mask),
      .rsp_selected        (rsp_selected),
      .rsp_display_changed (rsp_display_changed),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .errors              (errors),
      .awaiting            (awaiting),
      .readouts_checked    (readouts_checked),
      .group_starts        (group_starts),
      .commits             (commits)
   );

   // offer one tick beat and hold it until taken, then maybe idle
   task automatic send_tick(input logic st, input logic sp, input logic md);
      @(negedge clock);
      req_valid       <= 1'b1;
      req_start_level <= st;
      req_stop_level  <= sp;
      req_mode_level  <= md;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      ticks_sent++;
      if (idling && $urandom_range(0, 4) == 0)
         repeat ($urandom_range(1, 5)) begin
            @(negedge clock);
            req_valid <= 1'b0;
         end
   endtask

   // drop valid and wait for every readout to come back
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (awaiting != 0)
         @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   task automatic write_press_ticks(input logic [LPT_W-1:0] value);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // one button gesture: long press, short press, mode or stop taps, quiet run or noise
   task automatic play_episode(input int unsigned press);
      int unsigned reach;
      int unsigned n;
      reach = (press > 40) ? 40 : press;
      case ($urandom_range(0, 9))
         0, 1, 2: begin
            n = reach + 1 + $urandom_range(0, 2 * reach + 3);
            repeat (n)
               send_tick(1'b1, $urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0);
            send_tick(1'b0, 1'b0, 1'b0);
         end
         3, 4: begin
            repeat ($urandom_range(1, 3)) send_tick(1'b0, 1'b0, 1'b1);
            repeat ($urandom_range(1, 3)) send_tick(1'b0, 1'b0, 1'b0);
         end
         5, 6: begin
            repeat ($urandom_range(1, 3)) send_tick(1'b0, 1'b1, 1'b0);
            repeat ($urandom_range(1, 2)) send_tick(1'b0, 1'b0, 1'b0);
         end
         7: repeat ($urandom_range(1, 40)) send_tick(1'b0, 1'b0, 1'b0);
         8: begin
            // press released short of the hold length
            repeat ($urandom_range(1, (reach > 1) ? reach : 1)) send_tick(1'b1, 1'b0, 1'b0);
            send_tick(1'b0, 1'b0, 1'b0);
         end
         default:
            repeat ($urandom_range(1, 10))
               send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)));
      endcase
   endtask

   // receiver: random stall bursts plus one long hold-off on request
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (long_stall_left > 0) begin
         long_stall_left = long_stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (long_stall_asks != long_stall_done) begin
         long_stall_done = long_stall_done + 1;
         long_stall_left = LONG_STALL - 1;
         rsp_ready <= 1'b0;
      end else if (ready_gap > 0) begin
         ready_gap = ready_gap - 1;
         rsp_ready <= 1'b0;
      end else if (idling && $urandom_range(0, 5) == 0) begin
         ready_gap = $urandom_range(1, 5) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // end the run if no beat moves on either side for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      int  target;
      bit  paused;
      paused = 1'b0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // default hold length: first readout flags a change, mode edge and held mode,
      // stop on a halted timer, a press far too short to fire
      send_tick(1'b0, 1'b0, 1'b0);
      send_tick(1'b0, 1'b1, 1'b0);
      send_tick(1'b0, 1'b0, 1'b1);
      send_tick(1'b0, 1'b0, 1'b1);
      send_tick(1'b0, 1'b0, 1'b0);
      send_tick(1'b1, 1'b0, 1'b0);
      send_tick(1'b0, 1'b0, 1'b0);

      // zero length fires on the press itself and again while held
      write_press_ticks(16'd0);
      send_tick(1'b1, 1'b0, 1'b0);
      send_tick(1'b1, 1'b0, 1'b0);
      repeat (4) send_tick(1'b0, 1'b0, 1'b0);
      send_tick(1'b0, 1'b1, 1'b0);
      send_tick(1'b0, 1'b0, 1'b0);
      // all three buttons in one tick
      send_tick(1'b1, 1'b1, 1'b1);
      send_tick(1'b0, 1'b0, 1'b0);

      // shortest non-zero hold, then stop the newly selected timer
      write_press_ticks(16'd1);
      send_tick(1'b1, 1'b0, 1'b0);
      send_tick(1'b1, 1'b0, 1'b0);
      send_tick(1'b0, 1'b0, 1'b1);
      send_tick(1'b0, 1'b1, 1'b0);
      send_tick(1'b0, 1'b0, 1'b0);

      // random gestures over a range of hold lengths
      for (int p = 0; p < 7; p++) begin
         write_press_ticks(press_plan[p][LPT_W-1:0]);
         if (p == 1)
            long_stall_asks++;
         if (p == 6)
            idling = 1'b0;
         target = ticks_sent + PHASE_TICKS;
         while (ticks_sent < target) begin
            play_episode(press_plan[p]);
            if (p == 3 && !paused && ticks_sent >= target - PHASE_TICKS / 2) begin
               drain();
               paused = 1'b1;
            end
         end
      end

      drain();
      $display("Sent %0d ticks, checked %0d readouts over hold lengths 0 to 65535",
               ticks_sent, readouts_checked);
      $display("Saw %0d group starts and %0d stop commits, with one long output stall",
               group_starts, commits);
      if (errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
